### src/tbd_pkg.sv
// ----------------------------------------------------------------------------
// tbd_pkg
// types, constants and round helpers shared by the tea block decrypt pipeline
// ----------------------------------------------------------------------------
package tbd_pkg;

  localparam int unsigned RoundCount = 32;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CfgIdxW    = 8;

  localparam logic [WordW-1:0] TeaDelta = 32'h9E37_79B9;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyZero  = 8'd0,
    RegKeyOne   = 8'd1,
    RegKeyTwo   = 8'd2,
    RegKeyThree = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] cipher_first;
    logic [WordW-1:0] cipher_second;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] plain_first;
    logic [WordW-1:0] plain_second;
  } out_item_t;

  typedef struct packed {
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
  } word_pair_t;

  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } key_t;

  // round sum seen by round r, counted from the first decryption round
  function automatic logic [WordW-1:0] round_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(TeaDelta) * 64'(RoundCount - r);
    return prod[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] w,
                                                input logic [WordW-1:0] sum,
                                                input logic [WordW-1:0] ka,
                                                input logic [WordW-1:0] kb);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    a = (w << 4) + ka;
    b = w + sum;
    c = (w >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

### src/tea_block_decrypt.sv
// ----------------------------------------------------------------------------
// tea_block_decrypt
// pipelined tea decryption, unless stalled, of one 64-bit block per cycle
// ----------------------------------------------------------------------------
// usage:
//   in channel : in_valid_i / in_stall_o, payload in_data_i (ciphertext words)
//   out channel: out_valid_o / out_stall_i, payload out_data_o (plaintext words)
//   cfg channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects key word 0..3,
//                cfg_data_i is the new value; other indexes are dropped.
//                write keys only with no request in flight (block does not check).
// path: from accept to result a request passes one row of round cells,
//   each round split over two registers, followed by the output register.
// throughput: one block per cycle; the pipeline moves whenever the output
//   register is empty or being taken.
// stall: while a result waits with out_stall_i high, the whole row freezes
//   and in_stall_o is raised; nothing is lost or repeated.
// reset: clears all valid bits and the four key words to zero.
// ----------------------------------------------------------------------------
module tea_block_decrypt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tbd_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tbd_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tbd_pkg::WordW-1:0]     cfg_data_i
);

  localparam int unsigned N = tbd_pkg::RoundCount;

  logic                adv;
  tbd_pkg::key_t       key_d, key_q;
  logic                vld [N+1];
  tbd_pkg::word_pair_t dat [N+1];
  logic [N-1:0]        vld_vec;
  logic                out_valid_q;
  tbd_pkg::out_item_t  out_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tbd_pkg::RegKeyZero:  key_d.k0 = cfg_data_i;
        tbd_pkg::RegKeyOne:   key_d.k1 = cfg_data_i;
        tbd_pkg::RegKeyTwo:   key_d.k2 = cfg_data_i;
        tbd_pkg::RegKeyThree: key_d.k3 = cfg_data_i;
        default:              key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign vld[0]    = in_valid_i;
  assign dat[0].w0 = in_data_i.cipher_first;
  assign dat[0].w1 = in_data_i.cipher_second;

  for (genvar r = 0; r < N; r++) begin : g_round
    tbd_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .sum_i   (tbd_pkg::round_sum(r)),
      .key_i   (key_q),
      .valid_i (vld[r]),
      .data_i  (dat[r]),
      .valid_o (vld[r+1]),
      .data_o  (dat[r+1])
    );
    assign vld_vec[r] = vld[r+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.plain_first  <= dat[N].w0;
      out_q.plain_second <= dat[N].w1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_frozen_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_vec))
    else $error("round row moved while output stalled");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o == $past(vld_vec[N-1]))
    else $error("output valid does not follow last round cell");

  a_first_cell_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 adv |=> vld_vec[0])
    else $error("accepted request missing from first round cell");

endmodule

### src/tbd_round_cell.sv
// ----------------------------------------------------------------------------
// tbd_round_cell
// one decryption round in two registered halves: second word, then first word
// ----------------------------------------------------------------------------
module tbd_round_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [tbd_pkg::WordW-1:0]   sum_i,
  input  tbd_pkg::key_t               key_i,
  input  logic                        valid_i,
  input  tbd_pkg::word_pair_t         data_i,
  output logic                        valid_o,
  output tbd_pkg::word_pair_t         data_o
);

  logic                valid_a_q;
  logic                valid_b_q;
  tbd_pkg::word_pair_t half_d, half_q;
  tbd_pkg::word_pair_t full_d, full_q;

  always_comb begin
    half_d    = data_i;
    half_d.w1 = data_i.w1 - tbd_pkg::mix_word(data_i.w0, sum_i, key_i.k2, key_i.k3);
    full_d    = half_q;
    full_d.w0 = half_q.w0 - tbd_pkg::mix_word(half_q.w1, sum_i, key_i.k0, key_i.k1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_q <= half_d;
      full_q <= full_d;
    end
  end

  assign valid_o = valid_b_q;
  assign data_o  = full_q;

endmodule
